@@ rtl/core/amrpu_pkg.sv @@
// Package for the address match ROM patch unit.
// Holds the shared constants, the action codes and the structs between modules.
// Depends on nothing.
`default_nettype none

package amrpu_pkg;

    localparam int NUM_ENTRIES = 5;
    localparam int ENTRY_IDX_W = 3;
    localparam int ADDR_W = 22;
    localparam int ENTRY_ADDR_W = 24;
    localparam int WORD_W = 16;
    localparam int ROM_IDX_W = 21;
    localparam int SLOT_W = 4;

    localparam logic [ADDR_W-1:0] UNLOCK_ADDR = 22'h000002;
    localparam logic [WORD_W-1:0] UNLOCK_WORD = 16'h0001;
    localparam logic [ADDR_W-1:0] WIN_LOW = 22'h000004;
    localparam logic [ADDR_W-1:0] WIN_HIGH = 22'h000020;

    typedef enum logic [2:0] {
        ACT_PATCHED = 3'd0,
        ACT_READ_FWD = 3'd1,
        ACT_ROM_READ = 3'd2,
        ACT_WRITE_FWD = 3'd3,
        ACT_WRITE_ABS = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        PART_ADDR_HIGH = 2'd0,
        PART_ADDR_LOW = 2'd1,
        PART_DATA = 2'd2
    } part_t;

    typedef struct packed {
        logic op;
        logic upper_lane;
        logic lower_lane;
        logic [ADDR_W-1:0] bus_address;
        logic [WORD_W-1:0] write_word;
    } req_t;

    typedef struct packed {
        logic en;
        logic [ENTRY_IDX_W-1:0] entry;
        part_t part;
        logic [WORD_W-1:0] word;
    } load_t;

    typedef struct packed {
        logic hit;
        logic [WORD_W-1:0] data;
    } match_t;

endpackage

`default_nettype wire

@@ rtl/core/amrpu_input_stage.sv @@
// Input register of the address match ROM patch unit.
// Captures one request transaction and holds it until the result stage takes it.
// Depends on amrpu_pkg.
`default_nettype none

module amrpu_input_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire amrpu_pkg::req_t req_in,
    input  wire logic           advance,
    output logic                s1_valid,
    output amrpu_pkg::req_t     s1_req
);

    logic s1_valid_reg;
    logic s1_valid_next;
    amrpu_pkg::req_t req_reg;

    assign in_ready = !s1_valid_reg || advance;
    assign s1_valid = s1_valid_reg;
    assign s1_req = req_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= req_in;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/amrpu_patch_table.sv @@
// Patch entry table of the address match ROM patch unit.
// Stores the entries, loads their parts and finds the lowest matching valid entry.
// Depends on amrpu_pkg.
`default_nettype none

module amrpu_patch_table (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire amrpu_pkg::load_t                   load,
    input  wire logic [amrpu_pkg::ADDR_W-1:0]       lookup_address,
    output amrpu_pkg::match_t                       match
);

    logic [amrpu_pkg::NUM_ENTRIES-1:0] entry_valid_reg;
    logic [amrpu_pkg::ENTRY_ADDR_W-1:0] entry_address_reg [amrpu_pkg::NUM_ENTRIES];
    logic [amrpu_pkg::WORD_W-1:0] entry_data_reg [amrpu_pkg::NUM_ENTRIES];
    logic [amrpu_pkg::NUM_ENTRIES-1:0] hit_vec;
    logic [amrpu_pkg::ENTRY_ADDR_W-1:0] wide_address;

    assign wide_address = {{(amrpu_pkg::ENTRY_ADDR_W - amrpu_pkg::ADDR_W){1'b0}},
                           lookup_address};

    always_comb
    begin
        for (int i = 0; i < amrpu_pkg::NUM_ENTRIES; i++)
        begin
            hit_vec[i] = entry_valid_reg[i] && (entry_address_reg[i] == wide_address);
        end
    end

    // The lowest-numbered matching entry wins.
    always_comb
    begin
        match.hit = 1'b0;
        match.data = '0;
        for (int i = amrpu_pkg::NUM_ENTRIES - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                match.hit = 1'b1;
                match.data = entry_data_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            for (int i = 0; i < amrpu_pkg::NUM_ENTRIES; i++)
            begin
                entry_address_reg[i] <= '0;
                entry_data_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < amrpu_pkg::NUM_ENTRIES; i++)
            begin
                if (load.en && (load.entry == i[amrpu_pkg::ENTRY_IDX_W-1:0]))
                begin
                    case (load.part)
                        amrpu_pkg::PART_ADDR_HIGH:
                        begin
                            entry_address_reg[i][23:16] <= load.word[7:0];
                        end
                        amrpu_pkg::PART_ADDR_LOW:
                        begin
                            entry_address_reg[i][15:0] <= load.word;
                        end
                        amrpu_pkg::PART_DATA:
                        begin
                            entry_data_reg[i] <= load.word;
                            entry_valid_reg[i] <= 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/address_match_rom_patch_unit.sv @@
// Path: a request is held in the input register, then its result in the result register.
// Throughput: one transaction per cycle unless out_ready stalls the single result stage.
// Reset: locked, all entries invalid, no cartridge, both stages empty.
// Top level of the address match ROM patch unit with decision and result register.
// Depends on amrpu_pkg, amrpu_input_stage and amrpu_patch_table.
`default_nettype none

module address_match_rom_patch_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write_enable,
    input  wire logic                                cfg_write_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                op,
    input  wire logic                                upper_lane,
    input  wire logic                                lower_lane,
    input  wire logic [amrpu_pkg::ADDR_W-1:0]        bus_address,
    input  wire logic [amrpu_pkg::WORD_W-1:0]        write_word,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [2:0]                               action,
    output logic [amrpu_pkg::WORD_W-1:0]             read_word,
    output logic [amrpu_pkg::ROM_IDX_W-1:0]          rom_word_index
);

    amrpu_pkg::req_t req_in;
    amrpu_pkg::req_t s1_req;
    amrpu_pkg::load_t load;
    amrpu_pkg::match_t match;
    logic s1_valid;
    logic advance;
    logic cart_reg;
    logic unlocked_reg;
    logic unlocked_next;
    logic out_valid_reg;
    logic out_valid_next;
    amrpu_pkg::action_t action_reg;
    amrpu_pkg::action_t action_next;
    logic [amrpu_pkg::WORD_W-1:0] read_word_reg;
    logic [amrpu_pkg::WORD_W-1:0] read_word_next;
    logic [amrpu_pkg::ROM_IDX_W-1:0] rom_index_reg;
    logic [amrpu_pkg::ROM_IDX_W-1:0] rom_index_next;
    logic in_window;
    logic [4:0] win_offset;
    logic [amrpu_pkg::SLOT_W-1:0] slot;
    logic [7:0] slot_scaled;
    logic [amrpu_pkg::ENTRY_IDX_W-1:0] which;
    logic [amrpu_pkg::SLOT_W-1:0] part_raw;

    assign req_in.op = op;
    assign req_in.upper_lane = upper_lane;
    assign req_in.lower_lane = lower_lane;
    assign req_in.bus_address = bus_address;
    assign req_in.write_word = write_word;

    assign advance = s1_valid && (!out_valid_reg || out_ready);

    amrpu_input_stage u_input_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_in   (req_in),
        .advance  (advance),
        .s1_valid (s1_valid),
        .s1_req   (s1_req)
    );

    amrpu_patch_table u_patch_table (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (load),
        .lookup_address (s1_req.bus_address),
        .match          (match)
    );

    // Entry window decode: slot is the word offset, split into entry and part.
    assign in_window = (s1_req.bus_address >= amrpu_pkg::WIN_LOW)
                    && (s1_req.bus_address <= amrpu_pkg::WIN_HIGH);
    assign win_offset = s1_req.bus_address[4:0] - amrpu_pkg::WIN_LOW[4:0];
    assign slot = win_offset[4:1];
    assign slot_scaled = {4'd0, slot} * 8'd11;
    assign which = slot_scaled[7:5];
    assign part_raw = slot - ({1'b0, which} * 4'd3);

    always_comb
    begin
        action_next = amrpu_pkg::ACT_ROM_READ;
        read_word_next = '0;
        rom_index_next = '0;
        unlocked_next = unlocked_reg;
        load.en = 1'b0;
        load.entry = which;
        load.part = amrpu_pkg::part_t'(part_raw[1:0]);
        load.word = s1_req.write_word;
        if (!s1_req.op)
        begin
            if (unlocked_reg && match.hit)
            begin
                action_next = amrpu_pkg::ACT_PATCHED;
                read_word_next = match.data;
            end
            else if (unlocked_reg && cart_reg)
            begin
                action_next = amrpu_pkg::ACT_READ_FWD;
            end
            else
            begin
                rom_index_next = s1_req.bus_address[amrpu_pkg::ADDR_W-1:1];
            end
        end
        else if (unlocked_reg && cart_reg)
        begin
            action_next = amrpu_pkg::ACT_WRITE_FWD;
        end
        else
        begin
            action_next = amrpu_pkg::ACT_WRITE_ABS;
            if ((s1_req.bus_address == amrpu_pkg::UNLOCK_ADDR)
                && (s1_req.write_word == amrpu_pkg::UNLOCK_WORD))
            begin
                unlocked_next = advance;
            end
            load.en = advance && in_window && s1_req.upper_lane && s1_req.lower_lane
                   && ({1'b0, which} < 4'(amrpu_pkg::NUM_ENTRIES));
        end
        if (!advance)
        begin
            unlocked_next = unlocked_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cart_reg <= 1'b0;
            unlocked_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                cart_reg <= cfg_write_data;
            end
            unlocked_reg <= unlocked_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            action_reg <= action_next;
            read_word_reg <= read_word_next;
            rom_index_reg <= rom_index_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign action = action_reg;
    assign read_word = read_word_reg;
    assign rom_word_index = rom_index_reg;

endmodule

`default_nettype wire
